// File: sv/lorenz_attractor_integrator_step_core_macros.svh
// Assertion macros for the Lorenz step core.
// Needs nothing else; included by the top level only.
`ifndef LORENZ_ATTRACTOR_INTEGRATOR_STEP_CORE_MACROS_SVH
`define LORENZ_ATTRACTOR_INTEGRATOR_STEP_CORE_MACROS_SVH

// implication checked on every edge outside reset
`define LRZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrz check failed");

// next-cycle implication, also checked across reset
`define LRZ_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lrz check failed");

`endif

// File: sv/lrz_pkg.sv
// Shared types, constants and Q8.24 saturating arithmetic for the Lorenz step core.
// No dependencies.
package lrz_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 24;
    localparam int PROD_W = 2 * DATA_W;
    localparam int COEF_W = 31;
    localparam int STEP_W = 25;
    localparam int METH_W = 2;
    localparam int ADDR_W = 5;
    localparam int EVALS  = 4;

    localparam logic [METH_W-1:0] METH_EULER = 2'd0;
    localparam logic [METH_W-1:0] METH_RK2   = 2'd1;

    localparam logic [2:0] REG_SIGMA  = 3'd0;
    localparam logic [2:0] REG_RHO    = 3'd1;
    localparam logic [2:0] REG_BETA   = 3'd2;
    localparam logic [2:0] REG_STEP   = 3'd3;
    localparam logic [2:0] REG_METHOD = 3'd4;

    localparam logic [DATA_W-1:0] W_SIXTH = DATA_W'(((64'd1 << FRAC_W) + 64'd3) / 64'd6);
    localparam logic [DATA_W-1:0] W_THIRD = DATA_W'(((64'd1 << FRAC_W) + 64'd1) / 64'd3);

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef t_word [2:0] t_vec;

    typedef struct packed {
        t_vec x;     // state the step started from
        t_vec acc;   // weighted slope sum
        t_vec pass;  // finished Euler or RK2 result
    } t_side;

    function automatic t_word sat_add(t_word a, t_word b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return t_word'(s[DATA_W-1:0]);
    endfunction

    function automatic t_word sat_sub(t_word a, t_word b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return t_word'(s[DATA_W-1:0]);
    endfunction

    function automatic t_prod mul_raw(t_word a, t_word b);
        return t_prod'(a) * t_prod'(b);
    endfunction

    // round half away from zero, then saturate
    function automatic t_word mul_round(t_prod p);
        logic            neg;
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] q;
        logic [PROD_W-1:0] lim;
        neg = p[PROD_W-1];
        m   = neg ? (~p + 1'b1) : p;
        q   = (m + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W;
        lim = neg ? (PROD_W'(1) << (DATA_W - 1)) : ((PROD_W'(1) << (DATA_W - 1)) - 1'b1);
        if (q > lim) begin
            q = lim;
        end
        return neg ? t_word'(~q[DATA_W-1:0] + 1'b1) : t_word'(q[DATA_W-1:0]);
    endfunction

endpackage

// File: sv/lrz_eval.sv
// One slope evaluation of the Lorenz field plus the advance and weighted accumulate.
// Seven register stages; uses lrz_pkg.
module lrz_eval import lrz_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_vec  i_state,
    input  t_side i_side,
    input  t_word i_step,
    input  t_word i_weight,
    input  t_word i_sigma,
    input  t_word i_rho,
    input  t_word i_beta,
    output logic  o_valid,
    output t_vec  o_state,
    output t_side o_side
);

    logic [6:0] r_v;
    t_side      r_sd [7];
    t_word      r_d, r_e;
    t_vec       r_s;
    t_prod      r_p [4];
    t_word      r_y2, r_y3;
    t_word      r_m [4];
    t_vec       r_k;
    t_prod      r_ph [3];
    t_prod      r_pw [3];
    t_vec       r_kh, r_kw;
    t_vec       r_sn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // S1: differences
            r_sd[0] <= i_side;
            r_d     <= sat_sub(i_state[1], i_state[0]);
            r_e     <= sat_sub(i_rho, i_state[2]);
            r_s     <= i_state;
            // S2: field products
            r_sd[1] <= r_sd[0];
            r_p[0]  <= mul_raw(i_sigma, r_d);
            r_p[1]  <= mul_raw(r_e, r_s[0]);
            r_p[2]  <= mul_raw(r_s[0], r_s[1]);
            r_p[3]  <= mul_raw(i_beta, r_s[2]);
            r_y2    <= r_s[1];
            // S3: round
            r_sd[2] <= r_sd[1];
            for (int i = 0; i < 4; i++) begin
                r_m[i] <= mul_round(r_p[i]);
            end
            r_y3    <= r_y2;
            // S4: slope
            r_sd[3] <= r_sd[2];
            r_k[0]  <= r_m[0];
            r_k[1]  <= sat_sub(r_m[1], r_y3);
            r_k[2]  <= sat_sub(r_m[2], r_m[3]);
            // S5: scale by step and weight
            r_sd[4] <= r_sd[3];
            for (int i = 0; i < 3; i++) begin
                r_ph[i] <= mul_raw(r_k[i], i_step);
                r_pw[i] <= mul_raw(r_k[i], i_weight);
            end
            // S6: round
            r_sd[5] <= r_sd[4];
            for (int i = 0; i < 3; i++) begin
                r_kh[i] <= mul_round(r_ph[i]);
                r_kw[i] <= mul_round(r_pw[i]);
            end
            // S7: advance and accumulate
            r_sd[6].x    <= r_sd[5].x;
            r_sd[6].pass <= r_sd[5].pass;
            for (int i = 0; i < 3; i++) begin
                r_sn[i]         <= sat_add(r_sd[5].x[i], r_kh[i]);
                r_sd[6].acc[i]  <= sat_add(r_sd[5].acc[i], r_kw[i]);
            end
        end
    end

    assign o_valid = r_v[6];
    assign o_state = r_sn;
    assign o_side  = r_sd[6];

endmodule

// File: sv/lorenz_attractor_integrator_step_core.sv
// Lorenz-63 step core: one (x, y, z) Q8.24 word in, the state one step dt later out,
// by Euler, RK2 midpoint or RK4 (methods 2 and 3 run RK4). Fully pipelined: a word can be
// taken every cycle; each word passes from input to output register through four chained
// slope evaluators of seven stages each plus a three-stage final update.
// The whole pipe stalls only while the output word is held. Uses lrz_pkg, lrz_eval.
`include "lorenz_attractor_integrator_step_core_macros.svh"

module lorenz_attractor_integrator_step_core import lrz_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [95:0]       s_axis_tdata,   // pos_x_in, pos_y_in, pos_z_in
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [95:0]       m_axis_tdata,   // pos_x_out, pos_y_out, pos_z_out
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [COEF_W-1:0] r_sigma, r_rho, r_beta;
    logic [STEP_W-1:0] r_step;
    logic [METH_W-1:0] r_method;
    logic [2:0]        w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma  <= COEF_W'(167772160);
            r_rho    <= COEF_W'(469762048);
            r_beta   <= COEF_W'(44744835);
            r_step   <= STEP_W'(167772);
            r_method <= METH_W'(2);
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_SIGMA:  r_sigma  <= pwdata[COEF_W-1:0];
                REG_RHO:    r_rho    <= pwdata[COEF_W-1:0];
                REG_BETA:   r_beta   <= pwdata[COEF_W-1:0];
                REG_STEP:   r_step   <= pwdata[STEP_W-1:0];
                REG_METHOD: r_method <= pwdata[METH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SIGMA:  prdata = {1'b0, r_sigma};
            REG_RHO:    prdata = {1'b0, r_rho};
            REG_BETA:   prdata = {1'b0, r_beta};
            REG_STEP:   prdata = {7'd0, r_step};
            REG_METHOD: prdata = {30'd0, r_method};
            default:    prdata = '0;
        endcase
    end

    t_word w_sigma, w_rho, w_beta, w_dt, w_half;
    logic  w_euler, w_rk2, w_en;

    assign w_sigma = t_word'({1'b0, r_sigma});
    assign w_rho   = t_word'({1'b0, r_rho});
    assign w_beta  = t_word'({1'b0, r_beta});
    assign w_dt    = t_word'({7'd0, r_step});
    assign w_half  = t_word'({8'd0, r_step[STEP_W-1:1]});
    assign w_euler = (r_method == METH_EULER);
    assign w_rk2   = (r_method == METH_RK2);

    logic  r_ovld;
    t_vec  r_out;
    assign w_en          = m_axis_tready || !r_ovld;
    assign s_axis_tready = w_en;

    // evaluator chain
    logic  w_iv [EVALS];
    t_vec  w_is [EVALS];
    t_side w_isd[EVALS];
    t_word w_h  [EVALS];
    t_word w_w  [EVALS];
    logic  w_ov [EVALS];
    t_vec  w_os [EVALS];
    t_side w_osd[EVALS];

    assign w_h[0] = w_euler ? w_dt : w_half;
    assign w_h[1] = w_rk2 ? w_dt : w_half;
    assign w_h[2] = w_dt;
    assign w_h[3] = w_dt;
    assign w_w[0] = t_word'(W_SIXTH);
    assign w_w[1] = t_word'(W_THIRD);
    assign w_w[2] = t_word'(W_THIRD);
    assign w_w[3] = t_word'(W_SIXTH);

    assign w_iv[0]       = s_axis_tvalid;
    assign w_is[0]       = t_vec'(s_axis_tdata);
    assign w_isd[0].x    = t_vec'(s_axis_tdata);
    assign w_isd[0].acc  = '0;
    assign w_isd[0].pass = '0;

    genvar g;
    generate
        for (g = 1; g < EVALS; g++) begin : g_link
            assign w_iv[g]       = w_ov[g-1];
            assign w_is[g]       = w_os[g-1];
            assign w_isd[g].x    = w_osd[g-1].x;
            assign w_isd[g].acc  = w_osd[g-1].acc;
            // Euler result is ready after the first pass, RK2 after the second
            if (g == 1) begin : g_p1
                assign w_isd[g].pass = w_os[g-1];
            end else if (g == 2) begin : g_p2
                assign w_isd[g].pass = w_euler ? w_osd[g-1].pass : w_os[g-1];
            end else begin : g_pn
                assign w_isd[g].pass = w_osd[g-1].pass;
            end
        end
        for (g = 0; g < EVALS; g++) begin : g_eval
            lrz_eval u_eval (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_en),
                .i_valid  (w_iv[g]),
                .i_state  (w_is[g]),
                .i_side   (w_isd[g]),
                .i_step   (w_h[g]),
                .i_weight (w_w[g]),
                .i_sigma  (w_sigma),
                .i_rho    (w_rho),
                .i_beta   (w_beta),
                .o_valid  (w_ov[g]),
                .o_state  (w_os[g]),
                .o_side   (w_osd[g])
            );
        end
    endgenerate

    // final update x + acc*dt, or the finished Euler or RK2 result
    logic [1:0] r_fv;
    t_side      r_fsd [2];
    t_prod      r_fp [3];
    t_vec       r_fr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv   <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_fv   <= {r_fv[0], w_ov[EVALS-1]};
            r_ovld <= r_fv[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fsd[0] <= w_osd[EVALS-1];
            r_fsd[1] <= r_fsd[0];
            for (int i = 0; i < 3; i++) begin
                r_fp[i] <= mul_raw(w_osd[EVALS-1].acc[i], w_dt);
                r_fr[i] <= mul_round(r_fp[i]);
                r_out[i] <= (w_euler || w_rk2) ? r_fsd[1].pass[i]
                                               : sat_add(r_fsd[1].x[i], r_fr[i]);
            end
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;

    `LRZ_ASSERT_NXT(a_rst_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)
    `LRZ_ASSERT_IMP(a_stall_holds_tail, i_clk, i_rst_n, $past(m_axis_tvalid && !m_axis_tready && i_rst_n), m_axis_tvalid && $stable(m_axis_tdata))
    `LRZ_ASSERT_NXT(a_stall_freezes_pipe, i_clk, i_rst_n && !w_en, $stable(r_fv) || !i_rst_n)

endmodule

// File: bench/lorenz_attractor_integrator_step_core_test.sv
// Regression bench for the Lorenz-63 step core: directed table then random words, each result
// checked against a typed-in state or a Q8.24 step predictor. Uses lrz_pkg and the core.
module lorenz_attractor_integrator_step_core_test;
    import lrz_pkg::*;

    typedef struct {
        t_word x;
        t_word y;
        t_word z;
    } t_state;

    typedef struct {
        t_word x;
        t_word y;
        t_word z;
        bit    known;    // expected state typed in
        t_state want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lorenz_attractor_integrator_step_core dut (.*);

    localparam t_word WMAX = 32'sh7fffffff;
    localparam t_word WMIN = 32'sh80000000;

    // register shadow
    logic [COEF_W-1:0] sig_r, rho_r, bet_r;
    logic [STEP_W-1:0] dt_r;
    logic [METH_W-1:0] meth_r;

    t_state next_state_q[$];
    int     errors = 0;
    int     send_idle_pct, recv_stall_pct;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_word q_add(t_word a, t_word b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(WMAX)) return WMAX;
        if (s < longint'(WMIN)) return WMIN;
        return t_word'(s);
    endfunction

    function automatic t_word q_sub(t_word a, t_word b);
        longint s;
        s = longint'(a) - longint'(b);
        if (s > longint'(WMAX)) return WMAX;
        if (s < longint'(WMIN)) return WMIN;
        return t_word'(s);
    endfunction

    function automatic t_word q_mul(t_word a, t_word b);
        longint p, m, q;
        p = longint'(a) * longint'(b);
        m = p < 0 ? -p : p;
        q = (m + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
        if (p < 0) begin
            q = -q;
            if (q < longint'(WMIN)) q = WMIN;
        end else if (q > longint'(WMAX)) begin
            q = WMAX;
        end
        return t_word'(q);
    endfunction

    function automatic t_state slope(t_state s);
        t_state k;
        t_word sg, rh, bt;
        sg = t_word'({1'b0, sig_r});
        rh = t_word'({1'b0, rho_r});
        bt = t_word'({1'b0, bet_r});
        k.x = q_mul(sg, q_sub(s.y, s.x));
        k.y = q_sub(q_mul(q_sub(rh, s.z), s.x), s.y);
        k.z = q_sub(q_mul(s.x, s.y), q_mul(bt, s.z));
        return k;
    endfunction

    function automatic t_state nudge(t_state x, t_state k, t_word h);
        t_state o;
        o.x = q_add(x.x, q_mul(k.x, h));
        o.y = q_add(x.y, q_mul(k.y, h));
        o.z = q_add(x.z, q_mul(k.z, h));
        return o;
    endfunction

    function automatic t_state lorenz_step(t_state x);
        t_state k, s, acc, o;
        t_word dt, half, w6, w3;
        dt   = t_word'({7'd0, dt_r});
        half = t_word'({7'd0, dt_r >> 1});
        w6   = t_word'(((64'd1 << FRAC_W) + 3) / 6);
        w3   = t_word'(((64'd1 << FRAC_W) + 1) / 3);
        k = slope(x);
        if (meth_r == METH_EULER) begin
            o = nudge(x, k, dt);
        end else if (meth_r == METH_RK2) begin
            s = slope(nudge(x, k, half));
            o = nudge(x, s, dt);
        end else begin
            acc = '{0, 0, 0};
            acc = nudge(acc, k, w6);
            k = slope(nudge(x, k, half));
            acc = nudge(acc, k, w3);
            k = slope(nudge(x, k, half));
            acc = nudge(acc, k, w3);
            k = slope(nudge(x, k, dt));
            acc = nudge(acc, k, w6);
            o = nudge(x, acc, dt);
        end
        return o;
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_SIGMA:  sig_r  = val[COEF_W-1:0];
            REG_RHO:    rho_r  = val[COEF_W-1:0];
            REG_BETA:   bet_r  = val[COEF_W-1:0];
            REG_STEP:   dt_r   = val[STEP_W-1:0];
            default:    meth_r = val[METH_W-1:0];
        endcase
    endtask

    task automatic configure(logic [30:0] sg, logic [30:0] rh, logic [30:0] bt,
                             logic [24:0] dt, logic [1:0] m);
        reg_write(REG_SIGMA, {1'b0, sg});
        reg_write(REG_RHO, {1'b0, rh});
        reg_write(REG_BETA, {1'b0, bt});
        reg_write(REG_STEP, {7'd0, dt});
        reg_write(REG_METHOD, {30'd0, m});
    endtask

    // one word on the input side; expectation queued on acceptance.
    // tvalid stays high after acceptance so words can follow back to back.
    task automatic send_word(t_word x, t_word y, t_word z, bit known, t_state want);
        t_state s;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        s = '{x, y, z};
        next_state_q.push_back(known ? want : lorenz_step(s));
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        do @(posedge i_clk); while (next_state_q.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_word rnd_word();
        case ($urandom_range(5))
            0: return t_word'($urandom);
            1: return $urandom_range(1) ? WMAX : WMIN;
            default: return t_word'(int'($urandom_range(0, 60 << 24)) - (30 << 24));
        endcase
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_state got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{t_word'(m_axis_tdata[31:0]), t_word'(m_axis_tdata[63:32]),
                    t_word'(m_axis_tdata[95:64])};
            if (next_state_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
            end else begin
                want = next_state_q.pop_front();
                if (got.x !== want.x) begin
                    errors++;
                    $display("%0t: x expected %h got %h", $time, want.x, got.x);
                end
                if (got.y !== want.y) begin
                    errors++;
                    $display("%0t: y expected %h got %h", $time, want.y, got.y);
                end
                if (got.z !== want.z) begin
                    errors++;
                    $display("%0t: z expected %h got %h", $time, want.z, got.z);
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("lorenz_attractor_integrator_step_core regression: fail");
        $finish;
    end

    initial begin
        t_stim_row table_rows[$];
        t_state nil;
        int ph;
        nil = '{0, 0, 0};
        send_idle_pct = 0; recv_stall_pct = 0;
        i_rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        sig_r = 31'd167772160; rho_r = 31'd469762048; bet_r = 31'd44744835;
        dt_r = 25'd167772; meth_r = 2'd2;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: origin is a fixed point for any method after reset
        table_rows.push_back('{0, 0, 0, 1, nil});
        table_rows.push_back('{32'sh01000000, 32'sh01000000, 32'sh01000000, 0, nil});
        table_rows.push_back('{WMAX, WMAX, WMAX, 0, nil});
        table_rows.push_back('{WMIN, WMIN, WMIN, 0, nil});
        table_rows.push_back('{WMAX, WMIN, 0, 0, nil});
        table_rows.push_back('{WMIN, WMAX, WMAX, 0, nil});
        table_rows.push_back('{-32'sd1, 32'sd1, -32'sd1, 0, nil});
        table_rows.push_back('{32'sh0a000000, -32'sh05000000, 32'sh14000000, 0, nil});
        foreach (table_rows[i]) send_word(table_rows[i].x, table_rows[i].y,
            table_rows[i].z, table_rows[i].known, table_rows[i].want);
        drain();

        // each method, unused code and extreme coefficients
        for (int m = 0; m < 4; m++) begin
            configure(31'd167772160, 31'd469762048, 31'd44744835, 25'd167772, 2'(m));
            foreach (table_rows[i]) send_word(table_rows[i].x, table_rows[i].y,
                table_rows[i].z, 0, nil);
            drain();
        end
        configure('1, '1, '1, 25'd16777216, 2'd2);
        foreach (table_rows[i]) send_word(table_rows[i].x, table_rows[i].y,
            table_rows[i].z, 0, nil);
        drain();
        configure('0, '0, '0, '0, 2'd1);
        send_word(32'sh01000000, 32'sh02000000, 32'sh03000000, 1,
                  '{32'sh01000000, 32'sh02000000, 32'sh03000000});
        drain();
        configure('1, '1, '1, '1, 2'd0);
        foreach (table_rows[i]) send_word(table_rows[i].x, table_rows[i].y,
            table_rows[i].z, 0, nil);
        drain();

        // random phases: the first with the default settings, each later one with new random settings
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (ph == 0) configure(31'd167772160, 31'd469762048, 31'd44744835,
                                   25'd167772, 2'd2);
            else configure(31'($urandom), 31'($urandom), 31'($urandom),
                           $urandom_range(3) == 0 ? 25'($urandom)
                                                  : 25'($urandom_range(0, 1 << 20)),
                           2'($urandom_range(3)));
            for (int n = 0; n < 160; n++) begin
                send_word(rnd_word(), rnd_word(), rnd_word(), 0, nil);
                if (n == 80 && ph == 1) begin
                    s_axis_tvalid <= 0;
                    do @(posedge i_clk); while (next_state_q.size() != 0);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("lorenz_attractor_integrator_step_core regression: pass");
        end else begin
            $display("lorenz_attractor_integrator_step_core regression: fail");
        end
        $finish;
    end
endmodule
